/* design/tcs_pkg.sv */
package tcs_pkg;

    // field widths fixed by the item formats
    localparam int KIND_W      = 1;
    localparam int TEX_IDX_W   = 6;
    localparam int TEXEL_W     = 8;
    localparam int COLUMN_W    = 8;
    localparam int HEIGHT_W    = 12;
    localparam int ADDR_W      = 13;
    localparam int PAIR_W      = 16;

    // packing of the slave-side tdata, lowest field first
    localparam int IDX_LSB     = 0;
    localparam int TEXEL_LSB   = IDX_LSB + TEX_IDX_W;
    localparam int COLUMN_LSB  = TEXEL_LSB + TEXEL_W;
    localparam int HEIGHT_LSB  = COLUMN_LSB + COLUMN_W;
    localparam int S_USED_W    = HEIGHT_LSB + HEIGHT_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // packing of the master-side tdata
    localparam int M_USED_W    = ADDR_W + PAIR_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_USED_W;

    // texture column depth
    localparam int TEX_DEPTH   = 1 << TEX_IDX_W;

    // item kinds carried in tuser
    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_SPAN = 1'b1;

    // fill values of the pair buffer
    localparam logic [TEXEL_W-1:0] PAD_BYTE   = 8'hFF;
    localparam logic [PAIR_W-1:0]  PAIR_EMPTY = 16'hFFFF;

    // result queue ahead of the master side
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 2);

    // default geometry
    localparam int SCREEN_HEIGHT_DEF  = 64;
    localparam int SCREEN_WIDTH_DEF   = 240;
    localparam int TEXTURE_LENGTH_DEF = 64;
    localparam int FRAC_BITS_DEF      = 16;

    // one frame write
    typedef struct packed {
        logic                last;
        logic [PAIR_W-1:0]   pair;
        logic [ADDR_W-1:0]   addr;
    } t_result;

endpackage

/* design/tcs_div.sv */
// restoring divider: (TEXTURE_LENGTH << FRAC_BITS) / divisor, one quotient bit per cycle
module tcs_div #(
    parameter int TEXTURE_LENGTH = tcs_pkg::TEXTURE_LENGTH_DEF,
    parameter int FRAC_BITS      = tcs_pkg::FRAC_BITS_DEF,
    parameter int QW             = $clog2(TEXTURE_LENGTH + 1) + FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcs_pkg::HEIGHT_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [QW-1:0]                o_quotient
);

    localparam int HW = tcs_pkg::HEIGHT_W;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [HW-1:0] r_rem;
    logic [HW-1:0] r_div;
    logic [QW-1:0] r_quo;

    logic [HW:0]   trial;
    logic [HW:0]   diff;
    logic          ge;

    // trial subtraction of one step
    always_comb begin
        trial = {r_rem, r_quo[QW-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= QW'(TEXTURE_LENGTH) << FRAC_BITS;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[HW-1:0] : trial[HW-1:0];
            r_quo <= {r_quo[QW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* design/texture_column_scaler_pixel_pairs.sv */
// channel  | direction | tdata fields (lsb first)                          | side bits
// ---------+-----------+---------------------------------------------------+-----------------
// s_*      | in        | texel_index, texel_value, column_x, line_height  | tuser = kind
// m_*      | out       | frame_address, pixel_pair                        | tlast = last
//
// a load is written into the texture column on acceptance; a span is accepted, runs the
// divider (zero height skips it and the multiply), then a multiply step, then walks the
// visited rows of each row phase in turn.
// reset is synchronous: the texture column is undefined until loaded, the pair buffer
// reads as 0xffff through per-row valid bits cleared at once, so no clearing pass.
// results go through a four-entry queue; an odd span's row walk pauses while it is full.
module texture_column_scaler_pixel_pairs #(
    parameter int SCREEN_HEIGHT  = tcs_pkg::SCREEN_HEIGHT_DEF,
    parameter int SCREEN_WIDTH   = tcs_pkg::SCREEN_WIDTH_DEF,
    parameter int TEXTURE_LENGTH = tcs_pkg::TEXTURE_LENGTH_DEF,
    parameter int FRAC_BITS      = tcs_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // texel_index, texel_value, column_x, line_height, zero padding
    input  logic [tcs_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [tcs_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // frame_address, pixel_pair, zero padding
    output logic [tcs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int MID  = SCREEN_HEIGHT / 2;
    localparam int RW   = $clog2(SCREEN_HEIGHT + 1);
    localparam int RI   = $clog2(SCREEN_HEIGHT);
    localparam int HHW  = tcs_pkg::HEIGHT_W - 1;
    localparam int PW   = FRAC_BITS + tcs_pkg::TEX_IDX_W;
    localparam int QW   = $clog2(TEXTURE_LENGTH + 1) + FRAC_BITS;
    localparam int XW   = $clog2(SCREEN_WIDTH + 1);
    localparam int LW0  = ((RW + XW > tcs_pkg::COLUMN_W) ? RW + XW : tcs_pkg::COLUMN_W) + 1;
    localparam int LW   = (LW0 < tcs_pkg::ADDR_W + 1) ? tcs_pkg::ADDR_W + 1 : LW0;
    localparam int TW   = tcs_pkg::TEXEL_W;
    localparam int CNTW = tcs_pkg::FIFO_CNT_W;
    localparam int PTRW = tcs_pkg::FIFO_PTR_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_WALK = 2'd3;

    // row phases of a span walk
    localparam logic [1:0] PH_SPAN  = 2'd0;
    localparam logic [1:0] PH_ABOVE = 2'd1;
    localparam logic [1:0] PH_BELOW = 2'd2;

    // control
    logic [1:0]      r_state;
    logic [1:0]      r_phase;
    logic [RW-1:0]   r_y;
    logic [RW-1:0]   r_ef;
    logic [RW-1:0]   r_ee;
    logic            r_d_emit;
    logic            r_d_even;
    logic [SCREEN_HEIGHT-1:0] r_pvalid;

    // span payload
    logic                          r_odd;
    logic [tcs_pkg::COLUMN_W-1:0]  r_x;
    logic [RW-1:0]                 r_ds;
    logic [RW-1:0]                 r_de;
    logic [HHW-1:0]                r_off;
    logic [PW-1:0]                 r_step;
    logic [PW-1:0]                 r_pos;

    // read stage payload
    logic                          r_d_upper;
    logic                          r_d_pvalid;
    logic                          r_d_last;
    logic [RI-1:0]                 r_d_row;
    logic [tcs_pkg::ADDR_W-1:0]    r_d_addr;

    // memories and their read registers
    logic [TW-1:0]                 r_tex_mem [tcs_pkg::TEX_DEPTH];
    logic [TW-1:0]                 r_tex_rd;
    logic [tcs_pkg::PAIR_W-1:0]    r_pair_mem [SCREEN_HEIGHT];
    logic [tcs_pkg::PAIR_W-1:0]    r_pair_rd;

    // result queue
    tcs_pkg::t_result              r_fifo [tcs_pkg::FIFO_DEPTH];
    logic [PTRW-1:0]               r_wp;
    logic [PTRW-1:0]               r_rp;
    logic [CNTW-1:0]               r_cnt;

    // input fields
    logic [tcs_pkg::TEX_IDX_W-1:0] in_idx;
    logic [TW-1:0]                 in_texel;
    logic [tcs_pkg::COLUMN_W-1:0]  in_x;
    logic [tcs_pkg::HEIGHT_W-1:0]  in_h;
    logic [HHW-1:0]                in_half;
    logic [RW-1:0]                 in_ds;
    logic [RW-1:0]                 in_de;
    logic [HHW-1:0]                in_off;
    logic                          s_xfer;
    logic                          load_xfer;
    logic                          span_xfer;
    logic                          div_start;

    // divider
    logic                          div_done;
    logic [QW-1:0]                 div_q;

    // walk
    logic [RW-1:0]                 hi;
    logic                          in_range;
    logic                          space_ok;
    logic                          issue;
    logic                          is_last;
    logic [RW-1:0]                 y_next;
    logic [LW-1:0]                 lin;

    // read stage result
    logic [tcs_pkg::PAIR_W-1:0]    d_pair;
    logic [tcs_pkg::PAIR_W-1:0]    d_out;
    logic                          pop;
    tcs_pkg::t_result              head;

    // unpack and work out the visible row range
    always_comb begin
        in_idx   = s_tdata[tcs_pkg::IDX_LSB +: tcs_pkg::TEX_IDX_W];
        in_texel = s_tdata[tcs_pkg::TEXEL_LSB +: TW];
        in_x     = s_tdata[tcs_pkg::COLUMN_LSB +: tcs_pkg::COLUMN_W];
        in_h     = s_tdata[tcs_pkg::HEIGHT_LSB +: tcs_pkg::HEIGHT_W];
        in_half  = in_h[tcs_pkg::HEIGHT_W-1:1];
        if (in_half >= HHW'(MID)) begin
            in_ds  = '0;
            in_off = in_half - HHW'(MID);
        end else begin
            in_ds  = RW'(HHW'(MID) - in_half);
            in_off = '0;
        end
        if (in_half >= HHW'(SCREEN_HEIGHT - MID)) begin
            in_de = RW'(SCREEN_HEIGHT);
        end else begin
            in_de = RW'(HHW'(MID) + in_half);
        end
    end

    assign s_tready  = (r_state == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign load_xfer = s_xfer && (s_tuser == tcs_pkg::KIND_LOAD);
    assign span_xfer = s_xfer && (s_tuser == tcs_pkg::KIND_SPAN);
    assign div_start = span_xfer && (in_h != '0);

    tcs_div #(
        .TEXTURE_LENGTH (TEXTURE_LENGTH),
        .FRAC_BITS      (FRAC_BITS),
        .QW             (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (in_h),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // walk control: bound of the phase, queue room, last flag, frame address
    always_comb begin
        case (r_phase)
            PH_SPAN:  hi = r_de;
            PH_ABOVE: hi = r_ds;
            default:  hi = r_ee;
        endcase
        in_range = (r_y < hi);
        space_ok = ((r_cnt + CNTW'(r_d_emit)) < CNTW'(tcs_pkg::FIFO_DEPTH));
        issue    = (r_state == ST_WALK) && in_range && (!r_odd || space_ok);
        y_next   = r_y + RW'(1);
        case (r_phase)
            PH_SPAN:  is_last = (y_next == r_de) && !(r_ef < r_ds) && !(r_de < r_ee);
            PH_ABOVE: is_last = (y_next == r_ds) && !(r_de < r_ee);
            default:  is_last = (y_next == r_ee);
        endcase
        lin = LW'(r_y) * LW'(SCREEN_WIDTH) + LW'(r_x);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_SPAN;
            r_y     <= '0;
            r_ef    <= '0;
            r_ee    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (span_xfer) begin
                        r_phase <= PH_SPAN;
                        r_y     <= in_ds;
                        r_state <= div_start ? ST_DIV : ST_WALK;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (issue) begin
                        r_y <= y_next;
                    end else if (!in_range) begin
                        case (r_phase)
                            PH_SPAN: begin
                                if (r_odd) begin
                                    r_phase <= PH_ABOVE;
                                    r_y     <= r_ef;
                                end else begin
                                    r_ef    <= r_ds;
                                    r_ee    <= r_de;
                                    r_state <= ST_IDLE;
                                end
                            end
                            PH_ABOVE: begin
                                r_phase <= PH_BELOW;
                                r_y     <= r_de;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // span parameters, step and texture position
    always_ff @(posedge i_clk) begin
        if (span_xfer) begin
            r_odd <= in_x[0];
            r_x   <= in_x;
            r_ds  <= in_ds;
            r_de  <= in_de;
            r_off <= in_off;
        end
        if (r_state == ST_DIV && div_done) begin
            r_step <= PW'(div_q);
        end
        if (r_state == ST_MUL) begin
            r_pos <= PW'(r_off * r_step);
        end else if (issue && r_phase == PH_SPAN) begin
            r_pos <= r_pos + r_step;
        end
    end

    // texture column memory
    always_ff @(posedge i_clk) begin
        if (load_xfer) begin
            r_tex_mem[in_idx] <= in_texel;
        end
        if (issue) begin
            r_tex_rd <= r_tex_mem[r_pos[PW-1:FRAC_BITS]];
        end
    end

    // pair buffer memory: even-column texels written from the read stage, read on issue
    always_ff @(posedge i_clk) begin
        if (r_d_even) begin
            r_pair_mem[r_d_row] <= {tcs_pkg::PAD_BYTE, r_tex_rd};
        end
        if (issue) begin
            r_pair_rd <= r_pair_mem[r_y[RI-1:0]];
        end
    end

    // read stage control and row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_emit <= 1'b0;
            r_d_even <= 1'b0;
            r_pvalid <= '0;
        end else begin
            r_d_emit <= issue && r_odd;
            r_d_even <= issue && !r_odd;
            if (issue && r_odd) begin
                r_pvalid[r_y[RI-1:0]] <= 1'b0;
            end
            if (r_d_even) begin
                r_pvalid[r_d_row] <= 1'b1;
            end
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_d_upper  <= (r_phase == PH_SPAN);
            r_d_pvalid <= r_pvalid[r_y[RI-1:0]];
            r_d_last   <= is_last;
            r_d_row    <= r_y[RI-1:0];
            r_d_addr   <= lin[tcs_pkg::ADDR_W:1];
        end
    end

    // merge the odd texel into the high byte
    always_comb begin
        d_pair = r_d_pvalid ? r_pair_rd : tcs_pkg::PAIR_EMPTY;
        d_out  = r_d_upper ? {r_tex_rd, d_pair[TW-1:0]} : d_pair;
    end

    // result queue pointers
    assign pop = m_tvalid && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_d_emit) begin
                r_wp <= r_wp + PTRW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PTRW'(1);
            end
            r_cnt <= r_cnt + CNTW'(r_d_emit) - CNTW'(pop);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (r_d_emit) begin
            r_fifo[r_wp] <= '{last: r_d_last, pair: d_out, addr: r_d_addr};
        end
    end

    // master side
    assign head     = r_fifo[r_rp];
    assign m_tvalid = (r_cnt != '0);
    assign m_tdata  = {{tcs_pkg::M_PAD_W{1'b0}}, head.pair, head.addr};
    assign m_tlast  = head.last;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int KIND_W         = tcs_pkg::KIND_W;
    localparam int TEX_IDX_W      = tcs_pkg::TEX_IDX_W;
    localparam int TEXEL_W        = tcs_pkg::TEXEL_W;
    localparam int COLUMN_W       = tcs_pkg::COLUMN_W;
    localparam int HEIGHT_W       = tcs_pkg::HEIGHT_W;
    localparam int ADDR_W         = tcs_pkg::ADDR_W;
    localparam int PAIR_W         = tcs_pkg::PAIR_W;
    localparam int S_TDATA_W      = tcs_pkg::S_TDATA_W;
    localparam int M_TDATA_W      = tcs_pkg::M_TDATA_W;
    localparam int IDX_LSB        = tcs_pkg::IDX_LSB;
    localparam int TEXEL_LSB      = tcs_pkg::TEXEL_LSB;
    localparam int COLUMN_LSB     = tcs_pkg::COLUMN_LSB;
    localparam int HEIGHT_LSB     = tcs_pkg::HEIGHT_LSB;
    localparam int TEX_DEPTH      = tcs_pkg::TEX_DEPTH;

    localparam int SCREEN_H       = tcs_pkg::SCREEN_HEIGHT_DEF;
    localparam int SCREEN_W       = tcs_pkg::SCREEN_WIDTH_DEF;
    localparam int TEX_LEN        = tcs_pkg::TEXTURE_LENGTH_DEF;
    localparam int FRAC           = tcs_pkg::FRAC_BITS_DEF;
    localparam int MID_ROW        = SCREEN_H / 2;
    localparam int RANDOM_ITEMS   = 380;
    localparam int QUIET_TAIL     = 60;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 3000;

    // one input transfer before packing
    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [TEX_IDX_W-1:0] idx;
        logic [TEXEL_W-1:0]   val;
        logic [COLUMN_W-1:0]  x;
        logic [HEIGHT_W-1:0]  h;
    } t_column_cmd;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // texel_index, texel_value, column_x, line_height
    logic [KIND_W-1:0]    s_tuser;   // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // frame_address, pixel_pair
    logic                 m_tlast;

    // mirror of the block state
    logic [TEXEL_W-1:0] texture_col [TEX_DEPTH];
    logic [PAIR_W-1:0]  pair_rows [SCREEN_H];
    int unsigned        even_first;
    int unsigned        even_end;

    tcs_pkg::t_result pending_frame_writes [$];
    tcs_pkg::t_result span_writes [$];
    int               errors;
    bit               idle_on;
    int unsigned      hold_off_cycles;
    int unsigned      quiet_cycles;

    texture_column_scaler_pixel_pairs i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // queue one frame write and free its pair entry
    function automatic void emit_row(int unsigned row, logic [COLUMN_W-1:0] x);
        tcs_pkg::t_result w;
        w.addr = ADDR_W'((row * SCREEN_W + int'(x)) / 2);
        w.pair = pair_rows[row];
        w.last = 1'b0;
        span_writes.push_back(w);
        pair_rows[row] = tcs_pkg::PAIR_EMPTY;
    endfunction

    // expected frame writes of one accepted transfer
    task automatic model_column_draw(input t_column_cmd c);
        int unsigned     half_h;
        int unsigned     draw_start;
        int unsigned     draw_end;
        int unsigned     y;
        longint unsigned step;
        longint unsigned pos;
        logic [TEXEL_W-1:0] texel;
        if (c.kind == tcs_pkg::KIND_LOAD) begin
            texture_col[c.idx] = c.val;
            return;
        end
        span_writes.delete();
        half_h = c.h / 2;
        draw_start = (half_h >= MID_ROW) ? 0 : MID_ROW - half_h;
        draw_end = MID_ROW + half_h;
        if (draw_end > SCREEN_H) draw_end = SCREEN_H;
        // walk the span rows through the texture
        if (c.h != 0) begin
            step = (64'(TEX_LEN) << FRAC) / c.h;
            pos = 64'(draw_start + half_h - MID_ROW) * step;
            for (y = draw_start; y < draw_end; y++) begin
                texel = texture_col[TEX_IDX_W'(pos >> FRAC)];
                pos += step;
                if (c.x[0]) begin
                    pair_rows[y] = {texel, pair_rows[y][TEXEL_W-1:0]};
                    emit_row(y, c.x);
                end else begin
                    pair_rows[y] = {tcs_pkg::PAD_BYTE, texel};
                end
            end
        end
        // odd column flushes the rest of the remembered even span
        if (c.x[0]) begin
            for (y = even_first; y < draw_start && y < SCREEN_H; y++) emit_row(y, c.x);
            for (y = draw_end; y < even_end && y < SCREEN_H; y++) emit_row(y, c.x);
            if (span_writes.size() != 0) span_writes[span_writes.size() - 1].last = 1'b1;
            foreach (span_writes[i]) pending_frame_writes.push_back(span_writes[i]);
        end else begin
            even_first = draw_start;
            even_end = draw_end;
        end
    endtask

    // offer one transfer, wait for the handshake, then predict
    task automatic send_item(input t_column_cmd c);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[IDX_LSB +: TEX_IDX_W] = c.idx;
        data[TEXEL_LSB +: TEXEL_W] = c.val;
        data[COLUMN_LSB +: COLUMN_W] = c.x;
        data[HEIGHT_LSB +: HEIGHT_W] = c.h;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= c.kind;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        model_column_draw(c);
    endtask

    task automatic send_load(input int unsigned idx, input int unsigned val);
        t_column_cmd c;
        c.kind = tcs_pkg::KIND_LOAD;
        c.idx = TEX_IDX_W'(idx);
        c.val = TEXEL_W'(val);
        c.x = COLUMN_W'($urandom);
        c.h = HEIGHT_W'($urandom);
        send_item(c);
    endtask

    task automatic send_span(input int unsigned x, input int unsigned h);
        t_column_cmd c;
        c.kind = tcs_pkg::KIND_SPAN;
        c.idx = TEX_IDX_W'($urandom);
        c.val = TEXEL_W'($urandom);
        c.x = COLUMN_W'(x);
        c.h = HEIGHT_W'(h);
        send_item(c);
    endtask

    // heights mostly around the screen size, some far beyond it
    function automatic int unsigned pick_height();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 60) return $urandom_range(1, 70);
        if (r < 85) return $urandom_range(71, 300);
        return $urandom_range(301, 4095);
    endfunction

    // odd span straight after reset finds nothing remembered
    task automatic test_empty_flush();
        send_span(1, 0);
        send_span(0, 0);
        send_span(3, 0);
    endtask

    // fill the whole texture column so that no span reads an unwritten texel
    task automatic test_texture_load();
        send_load(0, 8'h00);
        send_load(TEX_DEPTH - 1, 8'hFF);
        for (int i = 1; i < TEX_DEPTH - 1; i++) send_load(i, $urandom_range(0, 255));
    endtask

    // clipping, short and zero heights, stray and wide columns
    task automatic test_span_corners();
        send_span(0, SCREEN_H);
        send_span(1, SCREEN_H);
        send_span(238, 1);
        send_span(239, 1);
        send_span(2, 4095);
        send_span(3, 10);
        send_span(4, 20);
        send_span(5, 0);
        send_span(7, 30);
        send_span(254, 2);
        send_span(255, 66);
        send_span(8, 0);
        send_span(9, 3);
        send_span(241, 4095);
        send_span(10, 127);
        send_span(11, 63);
        send_span(12, 65);
        send_span(13, 4094);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        hold_off_cycles = LONG_HOLD;
        for (int i = 0; i < 8; i++) begin
            send_span(2 * i + 20, $urandom_range(64, 4095));
            send_span(2 * i + 21, $urandom_range(64, 4095));
        end
    endtask

    // mostly even/odd pairs, some loads and lone columns
    task automatic test_random_columns();
        int          sent;
        int unsigned r;
        int unsigned x;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_load($urandom_range(0, TEX_DEPTH - 1), $urandom_range(0, 255));
                sent++;
            end else if (r < 80) begin
                x = 2 * $urandom_range(0, 127);
                send_span(x, pick_height());
                send_span(x + 1, pick_height());
                sent += 2;
            end else begin
                send_span($urandom_range(0, 255), pick_height());
                sent++;
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        tcs_pkg::t_result exp_w;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_frame_writes.size() == 0) begin
                $error("unexpected frame write: address %0d pair %h",
                       m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: PAIR_W]);
                errors++;
            end else begin
                exp_w = pending_frame_writes.pop_front();
                if (m_tdata[ADDR_W-1:0] !== exp_w.addr) begin
                    $error("frame_address: expected %0d, got %0d",
                           exp_w.addr, m_tdata[ADDR_W-1:0]);
                    errors++;
                end
                if (m_tdata[ADDR_W +: PAIR_W] !== exp_w.pair) begin
                    $error("pixel_pair: expected %h, got %h",
                           exp_w.pair, m_tdata[ADDR_W +: PAIR_W]);
                    errors++;
                end
                if (m_tlast !== exp_w.last) begin
                    $error("last: expected %0b, got %0b", exp_w.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = tcs_pkg::KIND_LOAD;
        errors = 0;
        idle_on = 1'b1;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        even_first = 0;
        even_end = 0;
        foreach (texture_col[i]) texture_col[i] = '0;
        foreach (pair_rows[i]) pair_rows[i] = tcs_pkg::PAIR_EMPTY;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_flush();
        test_texture_load();
        test_span_corners();
        test_output_backpressure();
        test_random_columns();
        s_tvalid <= 1'b0;

        // drain outstanding frame writes
        while (pending_frame_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
design/tcs_pkg.sv
design/tcs_div.sv
design/texture_column_scaler_pixel_pairs.sv
test/tb_top.sv
